// File: rtl/octb_pkg.sv
package octb_pkg;

  // Bank geometry
  localparam int SLOTS  = 8;
  localparam int SLOT_W = 3;
  localparam int POS_W  = 4;
  localparam int REM_W  = 26;
  localparam int SEC_W  = 16;
  localparam int MS_W   = 16;

  localparam logic [REM_W-1:0] MS_PER_SEC = REM_W'(1000);
  localparam logic [SEC_W-1:0] MIN_PERIOD_RST = SEC_W'(1);

  // Request op codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  // Access bundle for the timer store
  typedef struct packed {
    logic              ord_re;
    logic [SLOT_W-1:0] ord_raddr;
    logic              ord_we;
    logic [SLOT_W-1:0] ord_waddr;
    logic [SLOT_W-1:0] ord_wdata;
    logic              rem_re;
    logic [SLOT_W-1:0] rem_raddr;
    logic              rem_we;
    logic [SLOT_W-1:0] rem_waddr;
    logic [REM_W-1:0]  rem_wdata;
  } mem_req_t;

  // One result
  typedef struct packed {
    logic [SLOT_W-1:0] expired_slot;
    logic              fired;
    logic [POS_W-1:0]  active_count;
    logic              last;
  } res_t;

endpackage

// File: rtl/ordered_countdown_timer_bank_top.sv
// Start: a reload state, then the acknowledge. Unused op or stop of an idle
//   slot: the acknowledge only; stop of a running slot: a walk over every
//   active entry first. Tick: each active entry costs one order-memory read
//   followed by one time-memory read, both with a registered read port.
// One request at a time; the input stalls until its last result is queued.
// Reset (rst_n low, synchronous) empties the list and sets the minimum period
//   to 1 s; the memories themselves are not cleared.
module ordered_countdown_timer_bank_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_op,
  input  logic [octb_pkg::SLOT_W-1:0]   in_slot,
  input  logic [octb_pkg::SEC_W-1:0]    in_period_sec,
  input  logic [octb_pkg::MS_W-1:0]     in_elapsed_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [octb_pkg::SLOT_W-1:0]   out_expired_slot,
  output logic                          out_fired,
  output logic [octb_pkg::POS_W-1:0]    out_active_count,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [octb_pkg::SEC_W-1:0]    cfg_min_period_sec
);
  import octb_pkg::*;

  logic [SEC_W-1:0]  min_period_r;
  mem_req_t          mreq;
  logic [SLOT_W-1:0] ord_rdata;
  logic [REM_W-1:0]  rem_rdata;
  logic              out_free;
  logic              push;
  res_t              push_res;
  logic              out_vld_r;
  res_t              out_res_r;

  // Minimum period register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_period_r <= MIN_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      min_period_r <= cfg_min_period_sec;
    end
  end

  octb_store u_store (
    .clk       (clk),
    .req       (mreq),
    .ord_rdata (ord_rdata),
    .rem_rdata (rem_rdata)
  );

  octb_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_slot       (in_slot),
    .in_period_sec (in_period_sec),
    .in_elapsed_ms (in_elapsed_ms),
    .min_period    (min_period_r),
    .mreq          (mreq),
    .ord_rdata     (ord_rdata),
    .rem_rdata     (rem_rdata),
    .out_free      (out_free),
    .push          (push),
    .push_res      (push_res)
  );

  // Output register
  assign out_free = !out_vld_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (push) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_res_r <= push_res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_expired_slot = out_res_r.expired_slot;
  assign out_fired        = out_res_r.fired;
  assign out_active_count = out_res_r.active_count;
  assign out_last         = out_res_r.last;

endmodule

// File: rtl/octb_store.sv
module octb_store (
  input  logic                          clk,
  input  octb_pkg::mem_req_t            req,
  output logic [octb_pkg::SLOT_W-1:0]   ord_rdata,
  output logic [octb_pkg::REM_W-1:0]    rem_rdata
);
  import octb_pkg::*;

  logic [SLOT_W-1:0] ord_mem [SLOTS];
  logic [REM_W-1:0]  rem_mem [SLOTS];

  // Active list order, one read and one write port
  always_ff @(posedge clk) begin
    if (req.ord_we) begin
      ord_mem[req.ord_waddr] <= req.ord_wdata;
    end
    if (req.ord_re) begin
      ord_rdata <= ord_mem[req.ord_raddr];
    end
  end

  // Remaining time per slot, one read and one write port
  always_ff @(posedge clk) begin
    if (req.rem_we) begin
      rem_mem[req.rem_waddr] <= req.rem_wdata;
    end
    if (req.rem_re) begin
      rem_rdata <= rem_mem[req.rem_raddr];
    end
  end

endmodule

// File: rtl/octb_ctrl.sv
module octb_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_op,
  input  logic [octb_pkg::SLOT_W-1:0]   in_slot,
  input  logic [octb_pkg::SEC_W-1:0]    in_period_sec,
  input  logic [octb_pkg::MS_W-1:0]     in_elapsed_ms,
  input  logic [octb_pkg::SEC_W-1:0]    min_period,
  output octb_pkg::mem_req_t            mreq,
  input  logic [octb_pkg::SLOT_W-1:0]   ord_rdata,
  input  logic [octb_pkg::REM_W-1:0]    rem_rdata,
  input  logic                          out_free,
  output logic                          push,
  output octb_pkg::res_t                push_res
);
  import octb_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_START = 7'b0000010,
    S_TREM  = 7'b0000100,
    S_TEVAL = 7'b0001000,
    S_TEND  = 7'b0010000,
    S_PEVAL = 7'b0100000,
    S_ACK   = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [POS_W-1:0]  cnt_r, cnt_nxt;
  logic [SLOTS-1:0]  mask_r, mask_nxt;
  logic [POS_W-1:0]  rd_r, rd_nxt;
  logic [POS_W-1:0]  wr_r, wr_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  logic [SLOT_W-1:0] pend_slot_r, pend_slot_nxt;
  logic [POS_W-1:0]  pend_cnt_r, pend_cnt_nxt;
  logic [SLOT_W-1:0] cur_r, cur_nxt;

  // Latched request payload
  logic [SLOT_W-1:0] slot_r;
  logic [SEC_W-1:0]  period_r;
  logic [MS_W-1:0]   elapsed_r;

  logic              accept;
  logic [POS_W-1:0]  rd_inc;
  logic [REM_W-1:0]  elapsed_ext;
  logic              expire;
  logic [SEC_W-1:0]  period_clamp;
  logic [REM_W-1:0]  load_ms;

  assign in_stall     = (state_r != S_IDLE);
  assign accept       = in_valid && !in_stall;
  assign rd_inc       = rd_r + POS_W'(1);
  assign elapsed_ext  = REM_W'(elapsed_r);
  assign expire       = (rem_rdata <= elapsed_ext);
  assign period_clamp = (period_r < min_period) ? min_period : period_r;
  assign load_ms      = REM_W'(period_clamp) * MS_PER_SEC;

  // Payload capture
  always_ff @(posedge clk) begin
    if (accept) begin
      slot_r    <= in_slot;
      period_r  <= in_period_sec;
      elapsed_r <= in_elapsed_ms;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    mask_nxt      = mask_r;
    rd_nxt        = rd_r;
    wr_nxt        = wr_r;
    pend_vld_nxt  = pend_vld_r;
    pend_slot_nxt = pend_slot_r;
    pend_cnt_nxt  = pend_cnt_r;
    cur_nxt       = cur_r;
    mreq          = '0;
    push          = 1'b0;
    push_res      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          rd_nxt = '0;
          wr_nxt = '0;
          unique case (in_op)
            OP_TICK: begin
              if (cnt_r != '0) begin
                mreq.ord_re    = 1'b1;
                mreq.ord_raddr = '0;
                state_nxt      = S_TREM;
              end
            end
            OP_START: state_nxt = S_START;
            OP_STOP: begin
              if (mask_r[in_slot]) begin
                mreq.ord_re    = 1'b1;
                mreq.ord_raddr = '0;
                state_nxt      = S_PEVAL;
              end else begin
                state_nxt = S_ACK;
              end
            end
            default: state_nxt = S_ACK;
          endcase
        end
      end

      // Reload the slot; append it when not already listed
      S_START: begin
        mreq.rem_we    = 1'b1;
        mreq.rem_waddr = slot_r;
        mreq.rem_wdata = load_ms;
        if (!mask_r[slot_r] && cnt_r < POS_W'(SLOTS)) begin
          mreq.ord_we     = 1'b1;
          mreq.ord_waddr  = cnt_r[SLOT_W-1:0];
          mreq.ord_wdata  = slot_r;
          cnt_nxt         = cnt_r + POS_W'(1);
          mask_nxt[slot_r] = 1'b1;
        end
        state_nxt = S_ACK;
      end

      // List entry in hand: fetch its time
      S_TREM: begin
        cur_nxt        = ord_rdata;
        mreq.rem_re    = 1'b1;
        mreq.rem_raddr = ord_rdata;
        state_nxt      = S_TEVAL;
      end

      // Decrement or retire one entry, compacting behind the read pointer
      S_TEVAL: begin
        if (!expire || !pend_vld_r || out_free) begin
          if (expire) begin
            if (pend_vld_r) begin
              push                  = 1'b1;
              push_res.expired_slot = pend_slot_r;
              push_res.fired        = 1'b1;
              push_res.active_count = pend_cnt_r;
              push_res.last         = 1'b0;
            end
            pend_vld_nxt   = 1'b1;
            pend_slot_nxt  = cur_r;
            pend_cnt_nxt   = cnt_r - rd_r + wr_r - POS_W'(1);
            mask_nxt[cur_r] = 1'b0;
          end else begin
            mreq.rem_we    = 1'b1;
            mreq.rem_waddr = cur_r;
            mreq.rem_wdata = rem_rdata - elapsed_ext;
            mreq.ord_we    = 1'b1;
            mreq.ord_waddr = wr_r[SLOT_W-1:0];
            mreq.ord_wdata = cur_r;
            wr_nxt         = wr_r + POS_W'(1);
          end
          rd_nxt = rd_inc;
          if (rd_inc < cnt_r) begin
            mreq.ord_re    = 1'b1;
            mreq.ord_raddr = rd_inc[SLOT_W-1:0];
            state_nxt      = S_TREM;
          end else begin
            state_nxt = S_TEND;
          end
        end
      end

      // Commit new length, flush the held expiry with the last marker
      S_TEND: begin
        cnt_nxt = wr_r;
        if (!pend_vld_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          push                  = 1'b1;
          push_res.expired_slot = pend_slot_r;
          push_res.fired        = 1'b1;
          push_res.active_count = pend_cnt_r;
          push_res.last         = 1'b1;
          pend_vld_nxt          = 1'b0;
          state_nxt             = S_IDLE;
        end
      end

      // Stop walk: copy every entry except the stopped slot
      S_PEVAL: begin
        if (ord_rdata != slot_r) begin
          mreq.ord_we    = 1'b1;
          mreq.ord_waddr = wr_r[SLOT_W-1:0];
          mreq.ord_wdata = ord_rdata;
          wr_nxt         = wr_r + POS_W'(1);
        end
        rd_nxt = rd_inc;
        if (rd_inc < cnt_r) begin
          mreq.ord_re    = 1'b1;
          mreq.ord_raddr = rd_inc[SLOT_W-1:0];
        end else begin
          cnt_nxt          = cnt_r - POS_W'(1);
          mask_nxt[slot_r] = 1'b0;
          state_nxt        = S_ACK;
        end
      end

      S_ACK: begin
        if (out_free) begin
          push                  = 1'b1;
          push_res.expired_slot = '0;
          push_res.fired        = 1'b0;
          push_res.active_count = cnt_r;
          push_res.last         = 1'b1;
          state_nxt             = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      mask_r     <= '0;
      rd_r       <= '0;
      wr_r       <= '0;
      pend_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      mask_r     <= mask_nxt;
      rd_r       <= rd_nxt;
      wr_r       <= wr_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_slot_r <= pend_slot_nxt;
    pend_cnt_r  <= pend_cnt_nxt;
    cur_r       <= cur_nxt;
  end

  // List length never exceeds the bank
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= POS_W'(SLOTS))
    else $error("active list longer than bank");

  // Between requests the membership mask matches the list length
  a_mask_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ($countones(mask_r) == int'(cnt_r)))
    else $error("membership mask out of step with list length");

  // Compaction write pointer stays behind the read pointer
  a_wr_behind: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TEVAL || state_r == S_PEVAL || state_r == S_TREM) |-> (wr_r <= rd_r))
    else $error("compaction pointer passed read pointer");

  // A result is only handed over when the output register can take it
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> out_free)
    else $error("result pushed into full output register");

  // A tick walk ends with no held expiry
  a_pend_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_vld_r)
    else $error("expiry left behind after tick");

endmodule

// File: tb/tb_ordered_countdown_timer_bank_top.sv
module tb_ordered_countdown_timer_bank_top;
  import octb_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD = 80;

  // One row of the directed plan; a config row carries its value in period
  typedef struct {
    bit               cfg;
    logic [1:0]       op;
    logic [SLOT_W-1:0] slot;
    logic [SEC_W-1:0] period;
    logic [MS_W-1:0]  ms;
    bit               typed;
    res_t             want;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_op = OP_TICK;
  logic [SLOT_W-1:0] in_slot = '0;
  logic [SEC_W-1:0]  in_period_sec = '0;
  logic [MS_W-1:0]   in_elapsed_ms = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [SLOT_W-1:0] out_expired_slot;
  logic              out_fired;
  logic [POS_W-1:0]  out_active_count;
  logic              out_last;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [SEC_W-1:0]  cfg_min_period_sec = '0;

  // Shadow copy of the timer bank
  logic [REM_W-1:0]  timer_ms [SLOTS];
  logic [SLOT_W-1:0] run_order [SLOTS];
  logic [POS_W-1:0]  run_count;
  logic [SEC_W-1:0]  floor_sec;

  res_t step_reports [$];
  res_t due_reports [$];
  int   mismatches = 0;
  bit   calm = 1'b0;
  bit   hold_pending = 1'b0;
  int   stall_left = 0;

  plan_row_t plan [29];

  ordered_countdown_timer_bank_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_slot            (in_slot),
    .in_period_sec      (in_period_sec),
    .in_elapsed_ms      (in_elapsed_ms),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_expired_slot   (out_expired_slot),
    .out_fired          (out_fired),
    .out_active_count   (out_active_count),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_min_period_sec (cfg_min_period_sec)
  );

  always #5 clk = ~clk;

  function automatic res_t ack(logic [POS_W-1:0] count);
    return '{expired_slot: '0, fired: 1'b0, active_count: count, last: 1'b1};
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d, want %0d", what, got, want);
    mismatches++;
  endtask

  // Apply one request to the shadow bank; reports land in step_reports
  task automatic advance_bank(logic [1:0] op, logic [SLOT_W-1:0] slot,
                              logic [SEC_W-1:0] period, logic [MS_W-1:0] ms);
    int pos;
    int j;
    logic [SLOT_W-1:0] s;
    logic [SEC_W-1:0] eff_sec;
    bit found;
    step_reports.delete();
    if (op == OP_TICK) begin
      pos = 0;
      while (pos < int'(run_count)) begin
        s = run_order[pos];
        if (timer_ms[s] <= REM_W'(ms)) begin
          for (j = pos; j + 1 < int'(run_count); j++) run_order[j] = run_order[j + 1];
          run_count--;
          step_reports.push_back('{expired_slot: s, fired: 1'b1,
                                   active_count: run_count, last: 1'b0});
        end else begin
          timer_ms[s] = timer_ms[s] - REM_W'(ms);
          pos++;
        end
      end
      if (step_reports.size() > 0) step_reports[step_reports.size() - 1].last = 1'b1;
    end else begin
      found = 1'b0;
      pos = 0;
      for (j = 0; j < int'(run_count); j++) begin
        if (!found && run_order[j] == slot) begin
          found = 1'b1;
          pos = j;
        end
      end
      if (op == OP_START) begin
        eff_sec = (period < floor_sec) ? floor_sec : period;
        timer_ms[slot] = REM_W'(32'(eff_sec) * 32'd1000);
        if (!found && int'(run_count) < SLOTS) begin
          run_order[run_count] = slot;
          run_count++;
        end
      end else if (op == OP_STOP && found) begin
        for (j = pos; j + 1 < int'(run_count); j++) run_order[j] = run_order[j + 1];
        run_count--;
      end
      step_reports.push_back(ack(run_count));
    end
  endtask

  // Offer one request and wait for it to be taken
  task automatic issue_request(logic [1:0] op, logic [SLOT_W-1:0] slot,
                               logic [SEC_W-1:0] period, logic [MS_W-1:0] ms,
                               bit typed, res_t want);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_slot       <= slot;
    in_period_sec <= period;
    in_elapsed_ms <= ms;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_bank(op, slot, period, ms);
    if (typed) due_reports.push_back(want);
    else foreach (step_reports[k]) due_reports.push_back(step_reports[k]);
  endtask

  // Drop valid, wait out every pending report plus the silent tick latency
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_floor(logic [SEC_W-1:0] value);
    settle();
    cfg_valid          <= 1'b1;
    cfg_min_period_sec <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    floor_sec = value;
  endtask

  // Mostly short periods and sub-second to few-second ticks, so timers expire
  task automatic run_random(int count, int hold_at);
    int unsigned roll;
    logic [1:0] op;
    logic [SEC_W-1:0] period;
    logic [MS_W-1:0] ms;
    res_t none;
    none = '0;
    for (int n = 0; n < count; n++) begin
      if (n == hold_at) hold_pending = 1'b1;
      roll = $urandom_range(0, 99);
      op = (roll < 40) ? OP_TICK : (roll < 75) ? OP_START :
           (roll < 95) ? OP_STOP : OP_UNUSED;
      roll = $urandom_range(0, 99);
      period = (roll < 80) ? SEC_W'($urandom_range(1, 8)) :
               (roll < 85) ? '0 : SEC_W'($urandom_range(0, 65535));
      roll = $urandom_range(0, 99);
      ms = (roll < 70) ? MS_W'($urandom_range(200, 3000)) :
           (roll < 80) ? MS_W'($urandom_range(0, 10)) :
           (roll < 85) ? '1 : MS_W'($urandom);
      issue_request(op, SLOT_W'($urandom_range(0, SLOTS - 1)), period, ms, 1'b0, none);
    end
  endtask

  task automatic check_result(res_t got);
    res_t want;
    if (due_reports.size() == 0) begin
      flag_mismatch("unrequested result, slot", got.expired_slot, -1);
    end else begin
      want = due_reports.pop_front();
      if (got.expired_slot !== want.expired_slot)
        flag_mismatch("expired_slot", got.expired_slot, want.expired_slot);
      if (got.fired !== want.fired) flag_mismatch("fired", got.fired, want.fired);
      if (got.active_count !== want.active_count)
        flag_mismatch("active_count", got.active_count, want.active_count);
      if (got.last !== want.last) flag_mismatch("last", got.last, want.last);
    end
  endtask

  // Result side: check each accepted result, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      check_result('{out_expired_slot, out_fired, out_active_count, out_last});
    if (stall_left == 0) begin
      if (hold_pending) begin
        stall_left = LONG_HOLD;
        hold_pending = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 4);
      end
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    // Directed plan: empty bank, reload, full bank, zero period, floor extremes
    plan[0]  = '{0, OP_TICK,   0, 0,     1000,  0, '0};
    plan[1]  = '{0, OP_STOP,   3, 0,     0,     1, ack(0)};
    plan[2]  = '{0, OP_UNUSED, 6, 65535, 65535, 1, ack(0)};
    plan[3]  = '{0, OP_START,  0, 1,     0,     1, ack(1)};
    plan[4]  = '{0, OP_START,  7, 65535, 0,     1, ack(2)};
    plan[5]  = '{0, OP_START,  5, 2,     0,     1, ack(3)};
    plan[6]  = '{0, OP_START,  0, 3,     0,     1, ack(3)};
    plan[7]  = '{0, OP_TICK,   0, 0,     0,     0, '0};
    plan[8]  = '{0, OP_TICK,   0, 0,     1999,  0, '0};
    plan[9]  = '{0, OP_TICK,   0, 0,     1,     0, '0};
    plan[10] = '{0, OP_START,  1, 1,     0,     0, '0};
    plan[11] = '{0, OP_START,  2, 1,     0,     0, '0};
    plan[12] = '{0, OP_START,  3, 1,     0,     0, '0};
    plan[13] = '{0, OP_START,  4, 1,     0,     0, '0};
    plan[14] = '{0, OP_START,  6, 1,     0,     0, '0};
    plan[15] = '{0, OP_START,  5, 1,     0,     0, '0};
    plan[16] = '{0, OP_START,  7, 1,     0,     0, '0};
    plan[17] = '{0, OP_TICK,   0, 0,     65535, 0, '0};
    plan[18] = '{0, OP_STOP,   7, 0,     0,     1, ack(0)};
    plan[19] = '{1, OP_TICK,   0, 0,     0,     0, '0};
    plan[20] = '{0, OP_START,  2, 0,     0,     1, ack(1)};
    plan[21] = '{0, OP_START,  4, 5,     0,     0, '0};
    plan[22] = '{0, OP_TICK,   0, 0,     0,     1,
                 '{expired_slot: 3'd2, fired: 1'b1, active_count: 4'd1, last: 1'b1}};
    plan[23] = '{1, OP_TICK,   0, 65535, 0,     0, '0};
    plan[24] = '{0, OP_START,  6, 3,     0,     0, '0};
    plan[25] = '{0, OP_TICK,   0, 0,     65535, 0, '0};
    plan[26] = '{0, OP_STOP,   4, 0,     0,     0, '0};
    plan[27] = '{0, OP_STOP,   6, 0,     0,     1, ack(0)};
    plan[28] = '{1, OP_TICK,   0, 1,     0,     0, '0};

    run_count = '0;
    floor_sec = MIN_PERIOD_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[r]) begin
      if (plan[r].cfg) set_floor(plan[r].period);
      else issue_request(plan[r].op, plan[r].slot, plan[r].period, plan[r].ms,
                         plan[r].typed, plan[r].want);
    end

    // Random phases over several floor settings; one long result-side hold
    run_random(60, 20);
    set_floor(SEC_W'($urandom_range(2, 6)));
    run_random(45, -1);
    set_floor(SEC_W'($urandom_range(1000, 65535)));
    run_random(10, -1);
    for (int s = 0; s < SLOTS; s++)
      issue_request(OP_STOP, SLOT_W'(s), SEC_W'($urandom), MS_W'($urandom), 1'b0, '0);
    set_floor(SEC_W'(1));
    calm = 1'b1;
    run_random(30, -1);

    settle();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/octb_pkg.sv
rtl/octb_store.sv
rtl/octb_ctrl.sv
rtl/ordered_countdown_timer_bank_top.sv
tb/tb_ordered_countdown_timer_bank_top.sv
